// File: rtl/gnp_pkg.sv
// Package for the gradient noise pixel unit: constants, codes, stage indexes
// and the pipeline record type. It depends on nothing else.
package gnp_pkg;

    localparam int GRID_SIDE = 64;
    localparam int COORD_W = 10;
    localparam int CELL_W = 9;
    localparam int GRID_W = 6;
    localparam int BANK_AW = 2 * (GRID_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int FADE_W = 16;
    localparam int MAG_W = 27;
    localparam int INV_SQRT2_Q16 = 46341;
    localparam int FADE_THREE = 196608;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [1:0] REG_CELL_SIZE = 2'd0;
    localparam logic [1:0] REG_OUT_MIN = 2'd1;
    localparam logic [1:0] REG_OUT_MAX = 2'd2;

    localparam int ST_DIV1_LAST = 10;
    localparam int ST_MEM = 11;
    localparam int ST_MUL = 12;
    localparam int ST_DOT = 13;
    localparam int ST_FADE_FIRST = 12;
    localparam int ST_FADE_LAST = 27;
    localparam int ST_SQ = 28;
    localparam int ST_CUBE = 29;
    localparam int ST_LX_MUL = 30;
    localparam int ST_LX_ADD = 31;
    localparam int ST_LY_MUL = 32;
    localparam int ST_LY_ADD = 33;
    localparam int ST_SC_MUL = 34;
    localparam int ST_SC_ADD = 35;
    localparam int ST_CLAMP = 36;
    localparam int ST_DIV2_FIRST = 37;
    localparam int ST_DIV2_LAST = 63;
    localparam int ST_OUT = 64;
    localparam int NUM_STAGES = 65;

    typedef struct packed {
        logic                valid;
        logic                op;
        logic                oog;
        logic [GRID_W-1:0]   col;
        logic [GRID_W-1:0]   row;
        logic [15:0]         gx;
        logic [15:0]         gy;
        logic [COORD_W-1:0]  xd;
        logic [COORD_W-1:0]  yd;
        logic [COORD_W-1:0]  rx;
        logic [COORD_W-1:0]  ry;
        logic [COORD_W-1:0]  qx;
        logic [COORD_W-1:0]  qy;
        logic [7:0][25:0]    prod;
        logic [3:0][26:0]    dot;
        logic [FADE_W-1:0]   tx;
        logic [FADE_W-1:0]   ty;
        logic [31:0]         ttx;
        logic [31:0]         tty;
        logic [16:0]         u;
        logic [16:0]         v;
        logic signed [44:0]  lp_bl;
        logic signed [44:0]  lp_br;
        logic signed [44:0]  lp_tl;
        logic signed [44:0]  lp_tr;
        logic signed [45:0]  bot;
        logic signed [45:0]  top;
        logic signed [47:0]  ph_b;
        logic signed [47:0]  ph_t;
        logic signed [34:0]  pl_b;
        logic signed [34:0]  pl_t;
        logic signed [33:0]  w;
        logic signed [34:0]  dk;
        logic signed [52:0]  pa;
        logic signed [51:0]  pb;
        logic signed [27:0]  cdp;
        logic signed [37:0]  n2;
        logic                neg;
        logic [MAG_W-1:0]    mag;
        logic [9:0]          rq;
        logic [MAG_W-1:0]    q;
        logic [15:0]         noise;
    } pipe_t;

endpackage

// File: rtl/gradient_noise_pixel_unit.sv
// Gradient noise pixel unit: a 65-stage pipeline with banked gradient tables.
// Depends on gnp_pkg for constants, codes and the pipeline record.
//
// Usage: items arrive on the s_ channel. s_tuser selects the operation: a
// write stores one gradient vector in the grid tables and gives no
// transaction on the m_ channel; a pixel gives exactly one result with the
// saturated Q8.8 noise level in m_tdata and the out-of-grid flag in m_tuser.
// The cfg_ channel writes cell_size, out_min and out_max; write it only while
// the pipeline is empty. It is always ready.
// Throughput is one item per cycle while m_tready does not hold the pipeline.
// The pipeline holds ten stages of bit-serial coordinate division, sixteen
// for the fade fraction, and twenty-seven for the final scaling division.
// The four corner gradients come from four table banks, split by row and
// column parity, one read per bank per cycle.
// Reset clears the valid bits and loads cell_size 16, out_min 0, out_max 256;
// table contents stay undefined until written. When m_tready is low with a
// result waiting, the whole pipeline holds and s_tready drops; nothing is lost or repeated.
module gradient_noise_pixel_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_x[9:0], pixel_y[19:10], grid_col[25:20], grid_row[31:26],
    // grad_x[47:32], grad_y[63:48]
    input  logic [63:0] s_tdata,
    // operation[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // noise_value[15:0]
    output logic [15:0] m_tdata,
    // out_of_grid[0]
    output logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    gnp_pkg::pipe_t p_reg  [gnp_pkg::NUM_STAGES];
    gnp_pkg::pipe_t p_next [gnp_pkg::NUM_STAGES];

    logic [8:0]  cell_size_reg;
    logic [15:0] out_min_reg;
    logic [15:0] out_max_reg;
    logic [8:0]  cell_eff;
    logic        ce;
    logic [31:0] rd_reg [4];

    assign cfg_ready = 1'b1;
    assign ce = !m_tvalid || m_tready;
    assign s_tready = ce;
    assign m_tvalid = p_reg[gnp_pkg::ST_OUT].valid &&
                      (p_reg[gnp_pkg::ST_OUT].op == gnp_pkg::OP_PIXEL);
    assign m_tdata = p_reg[gnp_pkg::ST_OUT].noise;
    assign m_tuser = p_reg[gnp_pkg::ST_OUT].oog;

    always_comb begin
        if (cell_size_reg == 9'd0) begin
            cell_eff = 9'd1;
        end else if (cell_size_reg > 9'd256) begin
            cell_eff = 9'd256;
        end else begin
            cell_eff = cell_size_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_size_reg <= 9'd16;
            out_min_reg <= 16'd0;
            out_max_reg <= 16'd256;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                gnp_pkg::REG_CELL_SIZE: cell_size_reg <= cfg_data[8:0];
                gnp_pkg::REG_OUT_MIN:   out_min_reg <= cfg_data;
                gnp_pkg::REG_OUT_MAX:   out_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Gradient banks, indexed by {row parity, column parity}.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic [1:0] BANK_ID = 2'(b);
        logic [31:0] mem [gnp_pkg::BANK_DEPTH];
        logic [gnp_pkg::GRID_W-1:0] colsel;
        logic [gnp_pkg::GRID_W-1:0] rowsel;
        logic [gnp_pkg::BANK_AW-1:0] raddr;
        logic [gnp_pkg::BANK_AW-1:0] waddr;
        logic wsel;
        gnp_pkg::pipe_t src;

        assign src = p_reg[gnp_pkg::ST_DIV1_LAST];
        assign colsel = (src.qx[0] == BANK_ID[0]) ? src.qx[gnp_pkg::GRID_W-1:0]
                                                 : src.qx[gnp_pkg::GRID_W-1:0] + 1'b1;
        assign rowsel = (src.qy[0] == BANK_ID[1]) ? src.qy[gnp_pkg::GRID_W-1:0]
                                                 : src.qy[gnp_pkg::GRID_W-1:0] + 1'b1;
        assign raddr = {rowsel[gnp_pkg::GRID_W-1:1], colsel[gnp_pkg::GRID_W-1:1]};
        assign waddr = {src.row[gnp_pkg::GRID_W-1:1], src.col[gnp_pkg::GRID_W-1:1]};
        assign wsel = ({src.row[0], src.col[0]} == BANK_ID);

        always_ff @(posedge aclk) begin
            if (ce && src.valid) begin
                if (src.op == gnp_pkg::OP_WRITE) begin
                    if (wsel) begin
                        mem[waddr] <= {src.gy, src.gx};
                    end
                end else begin
                    rd_reg[b] <= mem[raddr];
                end
            end
        end
    end

    always_comb begin
        gnp_pkg::pipe_t p;
        logic [9:0] t10;
        logic [9:0] cell10;
        logic [9:0] d2;
        logic [1:0] bk;
        logic signed [9:0] dxl;
        logic signed [9:0] dxr;
        logic signed [9:0] dyb;
        logic signed [9:0] dyt;
        logic signed [9:0] dx;
        logic signed [9:0] dy;
        logic signed [25:0] pr;
        logic [31:0] g;
        logic [17:0] k18;
        logic [49:0] fp;
        logic signed [17:0] wu;
        logic signed [17:0] wu1;
        logic signed [17:0] wv;
        logic signed [17:0] wv1;
        logic signed [48:0] phs;
        logic signed [35:0] pls;
        logic signed [63:0] vsum;
        logic signed [16:0] diff;
        logic signed [17:0] wh;
        logic signed [16:0] wl;
        logic signed [68:0] asum;
        logic signed [27:0] c28;
        logic signed [27:0] r28;
        logic signed [28:0] res;
        int bi;

        cell10 = {1'b0, cell_eff};
        d2 = {cell_eff, 1'b0};
        diff = 17'($signed(out_max_reg)) - 17'($signed(out_min_reg));

        p_next[0] = p_reg[0];
        p_next[0].valid = s_tvalid;
        p_next[0].op = s_tuser[0];
        p_next[0].xd = s_tdata[9:0];
        p_next[0].yd = s_tdata[19:10];
        p_next[0].col = s_tdata[25:20];
        p_next[0].row = s_tdata[31:26];
        p_next[0].gx = s_tdata[47:32];
        p_next[0].gy = s_tdata[63:48];
        p_next[0].rx = '0;
        p_next[0].ry = '0;
        p_next[0].qx = '0;
        p_next[0].qy = '0;

        for (int s = 1; s < gnp_pkg::NUM_STAGES; s++) begin
            p = p_reg[s-1];
            if (s <= gnp_pkg::ST_DIV1_LAST) begin
                bi = gnp_pkg::COORD_W - s;
                t10 = {p.rx[8:0], p.xd[bi]};
                if (t10 >= cell10) begin
                    p.rx = t10 - cell10;
                    p.qx[bi] = 1'b1;
                end else begin
                    p.rx = t10;
                end
                t10 = {p.ry[8:0], p.yd[bi]};
                if (t10 >= cell10) begin
                    p.ry = t10 - cell10;
                    p.qy[bi] = 1'b1;
                end else begin
                    p.ry = t10;
                end
            end
            if (s == gnp_pkg::ST_MEM) begin
                p.oog = (p.qx >= 10'(gnp_pkg::GRID_SIDE - 1)) ||
                        (p.qy >= 10'(gnp_pkg::GRID_SIDE - 1));
                p.tx = '0;
                p.ty = '0;
            end
            if (s == gnp_pkg::ST_MUL) begin
                dxl = $signed({1'b0, p.rx[8:0]});
                dxr = dxl - $signed(cell10);
                dyb = $signed({1'b0, p.ry[8:0]});
                dyt = dyb - $signed(cell10);
                for (int c = 0; c < 4; c++) begin
                    bk = {p.qy[0] ^ c[1], p.qx[0] ^ c[0]};
                    g = rd_reg[bk];
                    dx = c[0] ? dxr : dxl;
                    dy = c[1] ? dyt : dyb;
                    pr = $signed(g[15:0]) * dx;
                    p.prod[2*c] = pr;
                    pr = $signed(g[31:16]) * dy;
                    p.prod[2*c+1] = pr;
                end
            end
            if (s == gnp_pkg::ST_DOT) begin
                for (int c = 0; c < 4; c++) begin
                    p.dot[c] = 27'($signed(p.prod[2*c])) + 27'($signed(p.prod[2*c+1]));
                end
            end
            if (s >= gnp_pkg::ST_FADE_FIRST && s <= gnp_pkg::ST_FADE_LAST) begin
                bi = gnp_pkg::FADE_W - 1 - (s - gnp_pkg::ST_FADE_FIRST);
                t10 = {p.rx[8:0], 1'b0};
                if (t10 >= cell10) begin
                    p.rx = t10 - cell10;
                    p.tx[bi] = 1'b1;
                end else begin
                    p.rx = t10;
                end
                t10 = {p.ry[8:0], 1'b0};
                if (t10 >= cell10) begin
                    p.ry = t10 - cell10;
                    p.ty[bi] = 1'b1;
                end else begin
                    p.ry = t10;
                end
            end
            if (s == gnp_pkg::ST_SQ) begin
                p.ttx = p.tx * p.tx;
                p.tty = p.ty * p.ty;
            end
            if (s == gnp_pkg::ST_CUBE) begin
                k18 = 18'(gnp_pkg::FADE_THREE) - {1'b0, p.tx, 1'b0};
                fp = p.ttx * k18;
                p.u = fp[48:32];
                k18 = 18'(gnp_pkg::FADE_THREE) - {1'b0, p.ty, 1'b0};
                fp = p.tty * k18;
                p.v = fp[48:32];
            end
            if (s == gnp_pkg::ST_LX_MUL) begin
                wu = $signed({1'b0, p.u});
                wu1 = 18'sd65536 - wu;
                p.lp_bl = $signed(p.dot[0]) * wu1;
                p.lp_br = $signed(p.dot[1]) * wu;
                p.lp_tl = $signed(p.dot[2]) * wu1;
                p.lp_tr = $signed(p.dot[3]) * wu;
            end
            if (s == gnp_pkg::ST_LX_ADD) begin
                p.bot = 46'(p.lp_bl) + 46'(p.lp_br);
                p.top = 46'(p.lp_tl) + 46'(p.lp_tr);
            end
            if (s == gnp_pkg::ST_LY_MUL) begin
                wv = $signed({1'b0, p.v});
                wv1 = 18'sd65536 - wv;
                p.ph_b = $signed(p.bot[45:16]) * wv1;
                p.pl_b = $signed({1'b0, p.bot[15:0]}) * wv1;
                p.ph_t = $signed(p.top[45:16]) * wv;
                p.pl_t = $signed({1'b0, p.top[15:0]}) * wv;
            end
            if (s == gnp_pkg::ST_LY_ADD) begin
                phs = 49'(p.ph_b) + 49'(p.ph_t);
                pls = 36'(p.pl_b) + 36'(p.pl_t);
                vsum = $signed({phs[47:0], 16'h0000}) + 64'(pls);
                p.w = vsum[63:30];
                p.dk = diff * 18'sd46341;
            end
            if (s == gnp_pkg::ST_SC_MUL) begin
                wh = p.w[33:16];
                wl = $signed({1'b0, p.w[15:0]});
                p.pa = p.dk * wh;
                p.pb = p.dk * wl;
                p.cdp = $signed(cell10) * (18'(diff) + 18'sd1);
            end
            if (s == gnp_pkg::ST_SC_ADD) begin
                asum = $signed({p.pa, 16'h0000}) + 69'(p.pb);
                p.n2 = 38'($signed(asum[68:32])) + 38'(p.cdp);
            end
            if (s == gnp_pkg::ST_CLAMP) begin
                if (p.n2 > 38'sd134217727) begin
                    c28 = 28'sd134217727;
                end else if (p.n2 < -38'sd134217728) begin
                    c28 = -28'sd134217728;
                end else begin
                    c28 = p.n2[27:0];
                end
                p.neg = c28[27];
                p.mag = c28[27] ? ~c28[26:0] : c28[26:0];
                p.rq = '0;
                p.q = '0;
            end
            if (s >= gnp_pkg::ST_DIV2_FIRST && s <= gnp_pkg::ST_DIV2_LAST) begin
                bi = gnp_pkg::MAG_W - 1 - (s - gnp_pkg::ST_DIV2_FIRST);
                t10 = {p.rq[8:0], p.mag[bi]};
                if (t10 >= d2) begin
                    p.rq = t10 - d2;
                    p.q[bi] = 1'b1;
                end else begin
                    p.rq = t10;
                end
            end
            if (s == gnp_pkg::ST_OUT) begin
                r28 = p.neg ? ~{1'b0, p.q} : {1'b0, p.q};
                res = 29'($signed(out_min_reg)) + 29'(r28);
                if (p.oog) begin
                    p.noise = '0;
                end else if (res > 29'sd32767) begin
                    p.noise = 16'h7fff;
                end else if (res < -29'sd32768) begin
                    p.noise = 16'h8000;
                end else begin
                    p.noise = res[15:0];
                end
            end
            p_next[s] = p;
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < gnp_pkg::NUM_STAGES; s++) begin
            if (!aresetn) begin
                p_reg[s].valid <= 1'b0;
            end else if (ce) begin
                p_reg[s] <= p_next[s];
            end
        end
    end

endmodule

// File: verif/tb_gradient_noise_pixel_unit.sv
// Self-checking testbench for gradient_noise_pixel_unit: gradient writes and pixel
// requests go through a bursty driver, results are checked against a built-in
// noise predictor. Depends on gnp_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_gradient_noise_pixel_unit;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 80;
    localparam int TABLE_DEPTH = gnp_pkg::GRID_SIDE * gnp_pkg::GRID_SIDE;
    localparam int LOW_CELLS = 10;

    typedef struct {
        logic        op;
        logic [9:0]  px;
        logic [9:0]  py;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [15:0] gx;
        logic [15:0] gy;
    } noise_item_t;

    typedef struct {
        logic [15:0] noise;
        logic        oog;
    } noise_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    noise_item_t   pending_items[$];
    noise_result_t expected_noise[$];
    logic [15:0]   grad_x_mem[TABLE_DEPTH];
    logic [15:0]   grad_y_mem[TABLE_DEPTH];
    logic [8:0]    cur_cell;
    logic [15:0]   cur_min;
    logic [15:0]   cur_max;
    int            fail_count;
    int            cycle_count;
    int            burst_left;
    int            gap_left;
    int            hold_req;
    int            hold_done;
    int            hold_left;
    int            stall_mode;
    int            stall_timer;

    gradient_noise_pixel_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint fade_frac(longint f, longint c);
        longint t;
        t = (f << 16) / c;
        return (t * t * (longint'(gnp_pkg::FADE_THREE) - 2 * t)) >> 32;
    endfunction

    function automatic longint corner_dot(int col, int row, longint dx, longint dy);
        int idx;
        idx = row * gnp_pkg::GRID_SIDE + col;
        return longint'($signed(grad_x_mem[idx])) * dx + longint'($signed(grad_y_mem[idx])) * dy;
    endfunction

    function automatic void predict_noise(noise_item_t it);
        noise_result_t res;
        longint c, cx, cy, fx, fy, bl, br, tl, tr, u, v, bot, top, val, w;
        longint diff, num, den, lvl;
        if (it.op == gnp_pkg::OP_WRITE) begin
            grad_x_mem[{it.row, it.col}] = it.gx;
            grad_y_mem[{it.row, it.col}] = it.gy;
            return;
        end
        c = cur_cell;
        if (c == 0) c = 1;
        if (c > 256) c = 256;
        cx = it.px / c;
        cy = it.py / c;
        if (cx + 1 >= gnp_pkg::GRID_SIDE || cy + 1 >= gnp_pkg::GRID_SIDE) begin
            res.noise = 16'd0;
            res.oog = 1'b1;
        end else begin
            fx = it.px - cx * c;
            fy = it.py - cy * c;
            bl = corner_dot(cx, cy, fx, fy);
            br = corner_dot(cx + 1, cy, fx - c, fy);
            tl = corner_dot(cx, cy + 1, fx, fy - c);
            tr = corner_dot(cx + 1, cy + 1, fx - c, fy - c);
            u = fade_frac(fx, c);
            v = fade_frac(fy, c);
            bot = bl * (65536 - u) + br * u;
            top = tl * (65536 - u) + tr * u;
            val = bot * (65536 - v) + top * v;
            w = floor_div(val, longint'(1) << 30);
            diff = longint'($signed(cur_max)) - longint'($signed(cur_min));
            den = c * (longint'(1) << 33);
            num = diff * c * (longint'(1) << 32) + diff * w * gnp_pkg::INV_SQRT2_Q16 +
                  den / 2;
            lvl = longint'($signed(cur_min)) + floor_div(num, den);
            if (lvl > 32767) lvl = 32767;
            if (lvl < -32768) lvl = -32768;
            res.noise = lvl[15:0];
            res.oog = 1'b0;
        end
        expected_noise.push_back(res);
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        logic next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                predict_noise(pending_items.pop_front());
                next_valid = 1'b0;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    next_valid = 1'b0;
                end else if (pending_items.size() > 0) begin
                    next_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
            if (next_valid) begin
                s_tdata <= {pending_items[0].gy, pending_items[0].gx, pending_items[0].row,
                            pending_items[0].col, pending_items[0].py, pending_items[0].px};
                s_tuser <= pending_items[0].op;
            end
            s_tvalid <= next_valid;
        end
    end

    // Receiver: stall_timer drives a random choice of stall mode; a requested long hold-off wins.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_done <= 0;
            stall_mode <= 0;
            stall_timer <= 0;
        end else begin
            stall_timer <= stall_timer + 1;
            if (stall_timer % 64 == 63) stall_mode <= $urandom_range(0, 2);
            if (hold_done != hold_req) begin
                hold_done <= hold_req;
                hold_left <= 300;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (stall_mode == 0) begin
                m_tready <= 1'b1;
            end else if (stall_mode == 1) begin
                m_tready <= $urandom_range(0, 1);
            end else begin
                m_tready <= ($urandom_range(0, 9) == 0);
            end
        end
    end

    always @(posedge aclk) begin
        noise_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_noise.size() == 0) begin
                $display("%0t: unexpected result noise=%h oog=%b", $time, m_tdata, m_tuser);
                fail_count = fail_count + 1;
            end else begin
                exp_res = expected_noise.pop_front();
                if (m_tdata !== exp_res.noise) begin
                    $display("%0t: noise_value expected %h actual %h", $time,
                             exp_res.noise, m_tdata);
                    fail_count = fail_count + 1;
                end
                if (m_tuser[0] !== exp_res.oog) begin
                    $display("%0t: out_of_grid expected %b actual %b", $time,
                             exp_res.oog, m_tuser[0]);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] rand_grad();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h4000;
            3: return 16'hC000;
            4: return $urandom();
            default: return $urandom_range(0, 32768) - 16384;
        endcase
    endfunction

    function automatic void push_write(int col, int row, logic [15:0] gx, logic [15:0] gy);
        noise_item_t it;
        it.op = gnp_pkg::OP_WRITE;
        it.px = $urandom();
        it.py = $urandom();
        it.col = col;
        it.row = row;
        it.gx = gx;
        it.gy = gy;
        pending_items.push_back(it);
    endfunction

    function automatic void push_pixel(int px, int py);
        noise_item_t it;
        it.op = gnp_pkg::OP_PIXEL;
        it.px = px;
        it.py = py;
        it.col = $urandom();
        it.row = $urandom();
        it.gx = $urandom();
        it.gy = $urandom();
        pending_items.push_back(it);
    endfunction

    // Grid lines that get gradients: the low corner and the last two lines.
    function automatic bit grid_line_used(int i);
        return (i < LOW_CELLS) || (i >= gnp_pkg::GRID_SIDE - 2);
    endfunction

    // Pixels either stay in the low corner, sit in the last cell or lie off the grid.
    function automatic int pick_coord(int c);
        int low_span;
        low_span = (LOW_CELLS - 1) * c;
        if (low_span > 1024) low_span = 1024;
        if (gnp_pkg::GRID_SIDE * c - c <= 1023 && $urandom_range(0, 7) == 0)
            return $urandom_range((gnp_pkg::GRID_SIDE - 2) * c, 1023);
        return $urandom_range(0, low_span - 1);
    endfunction

    function automatic void push_random(int n);
        int c;
        c = (cur_cell == 0) ? 1 : ((cur_cell > 256) ? 256 : int'(cur_cell));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                push_write($urandom_range(0, 63), $urandom_range(0, 63), rand_grad(),
                           rand_grad());
            else
                push_pixel(pick_coord(c), pick_coord(c));
        end
    endfunction

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_items.size() != 0 || expected_noise.size() != 0 || s_tvalid);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(logic [8:0] cell_val, logic [15:0] lo, logic [15:0] hi);
        logic [1:0]  idx[3];
        logic [15:0] val[3];
        idx = '{gnp_pkg::REG_CELL_SIZE, gnp_pkg::REG_OUT_MIN, gnp_pkg::REG_OUT_MAX};
        val = '{{7'd0, cell_val}, lo, hi};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge aclk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_cell = cell_val;
        cur_min = lo;
        cur_max = hi;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        cycle_count = 0;
        hold_req = 0;
        cur_cell = 9'd16;
        cur_min = 16'h0000;
        cur_max = 16'h0100;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Every table entry that a pixel may read is written first.
        for (int r = 0; r < gnp_pkg::GRID_SIDE; r++)
            for (int c = 0; c < gnp_pkg::GRID_SIDE; c++)
                if (grid_line_used(r) && grid_line_used(c))
                    push_write(c, r, rand_grad(), rand_grad());
        push_write(0, 0, 16'h7FFF, 16'h7FFF);
        push_write(1, 0, 16'h8000, 16'h8000);
        push_write(0, 1, 16'h4000, 16'hC000);
        push_write(1, 1, 16'hC000, 16'h4000);
        push_pixel(0, 0);
        push_pixel(15, 15);
        push_pixel(8, 8);
        push_pixel(1007, 1007);
        push_pixel(1008, 0);
        push_pixel(0, 1008);
        push_pixel(1023, 1023);
        push_pixel(100, 133);
        wait_idle();

        write_regs(9'd1, 16'h8000, 16'h7FFF);
        push_pixel(0, 0);
        push_pixel(62, 62);
        push_pixel(63, 0);
        push_random(100);
        hold_req = hold_req + 1;
        wait_idle();

        write_regs(9'd256, 16'h7FFF, 16'h8000);
        push_pixel(0, 0);
        push_pixel(255, 255);
        push_pixel(767, 767);
        push_random(100);
        wait_idle();

        write_regs(9'd0, 16'h0100, 16'h0100);
        push_random(50);
        wait_idle();

        write_regs(9'd511, 16'hFF00, 16'h0200);
        push_random(50);
        wait_idle();

        write_regs($urandom_range(2, 40), $urandom(), $urandom());
        push_random(100);
        wait_idle();

        write_regs(9'd16, 16'h0000, 16'h0100);
        push_random(80);
        wait_idle();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
